// ===== sv/i2cmts_pkg.sv =====
`default_nettype none

package i2cmts_pkg;

  // Default width of the byte counters.
  localparam int I2CMTS_COUNT_WIDTH = 16;

  // Input operations.
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Bus action codes.
  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_ADDR    = 3'd1;
  localparam logic [2:0] ACT_WRITE   = 3'd2;
  localparam logic [2:0] ACT_RD_ACK  = 3'd3;
  localparam logic [2:0] ACT_RD_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;
  localparam logic [2:0] ACT_NONE    = 3'd6;

  // Status codes.
  localparam logic [2:0] ST_BUSY   = 3'd0;
  localparam logic [2:0] ST_OK     = 3'd1;
  localparam logic [2:0] ST_ABORT  = 3'd2;
  localparam logic [2:0] ST_DEVERR = 3'd3;
  localparam logic [2:0] ST_IDLE   = 3'd4;

  // Saved flag bit positions.
  localparam int FLAG_STOP  = 0;
  localparam int FLAG_BREAK = 1;
  localparam int FLAG_NLAST = 2;

  // Most results one input item can cause.
  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic        operation;
    logic [6:0]  device_address;
    logic        is_read;
    logic [15:0] byte_count;
    logic        want_start;
    logic        want_stop;
    logic        break_on_nack;
    logic        nack_last;
    logic [7:0]  write_data;
    logic        slave_nack;
    logic [7:0]  slave_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  bus_action;
    logic [7:0]  byte_value;
    logic        nack_seen;
    logic [15:0] bytes_done;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] byte_value;
    logic       nack_seen;
  } action_t;

  // All results of one input item; they share bytes_done and status.
  typedef struct packed {
    action_t [MAX_RESULTS-1:0] entry;
    logic [1:0]                count;
    logic [15:0]               bytes_done;
    logic [2:0]                status;
  } bundle_t;

endpackage

`default_nettype wire

// ===== sv/i2cmts_core.sv =====
`default_nettype none

module i2cmts_core
  import i2cmts_pkg::*;
#(
  parameter int COUNT_WIDTH = I2CMTS_COUNT_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t item,
  input  logic     commit,
  output bundle_t  bundle
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic                   active, active_next;
  logic                   reading, reading_next;
  logic [COUNT_WIDTH-1:0] remaining, remaining_next;
  logic [COUNT_WIDTH-1:0] completed, completed_next;
  logic [2:0]             saved_flags, saved_flags_next;

  logic [COUNT_WIDTH-1:0] count_sat;
  logic [15:0]            done_view;
  logic                   do_close;
  logic [2:0]             close_status;
  logic [2:0]             status;
  logic [1:0]             num;
  action_t [MAX_RESULTS-1:0] ent;

  generate
    if (COUNT_WIDTH >= 16) begin : g_wide
      assign count_sat = COUNT_WIDTH'(item.byte_count);
      assign done_view = completed_next[15:0];
    end else begin : g_narrow
      assign count_sat = (|item.byte_count[15:COUNT_WIDTH]) ? CountMax
                                                            : item.byte_count[COUNT_WIDTH-1:0];
      assign done_view = 16'(completed_next);
    end
  endgenerate

  always_comb begin
    active_next      = active;
    reading_next     = reading;
    remaining_next   = remaining;
    completed_next   = completed;
    saved_flags_next = saved_flags;
    do_close         = 1'b0;
    close_status     = ST_OK;
    status           = ST_BUSY;
    num              = 2'd0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      ent[k] = '{bus_action: ACT_NONE, byte_value: 8'd0, nack_seen: 1'b0};
    end

    if (item.operation == OP_BEGIN) begin
      saved_flags_next = {item.nack_last, item.break_on_nack, item.want_stop};
      reading_next     = item.is_read;
      remaining_next   = count_sat;
      completed_next   = '0;
      active_next      = 1'b1;
      if (item.want_start) begin
        ent[num] = '{bus_action: ACT_START, byte_value: 8'd0, nack_seen: 1'b0};
        num      = num + 2'd1;
      end
      ent[num] = '{bus_action: ACT_ADDR, byte_value: {item.device_address, item.is_read},
                   nack_seen: item.slave_nack};
      num      = num + 2'd1;
      if (item.slave_nack) begin
        do_close     = 1'b1;
        close_status = ST_DEVERR;
      end else if (count_sat == '0) begin
        do_close     = 1'b1;
        close_status = ST_OK;
      end
    end else if (!active) begin
      ent[0] = '{bus_action: ACT_NONE, byte_value: 8'd0, nack_seen: 1'b0};
      num    = 2'd1;
      status = ST_IDLE;
    end else begin
      if (reading) begin
        ent[0] = '{bus_action: (remaining == COUNT_WIDTH'(1) && saved_flags[FLAG_NLAST])
                               ? ACT_RD_NACK : ACT_RD_ACK,
                   byte_value: item.slave_data, nack_seen: 1'b0};
      end else begin
        ent[0] = '{bus_action: ACT_WRITE, byte_value: item.write_data,
                   nack_seen: item.slave_nack};
      end
      num = 2'd1;
      if (!reading && item.slave_nack && saved_flags[FLAG_BREAK]) begin
        // The refused byte is not counted.
        do_close     = 1'b1;
        close_status = ST_ABORT;
      end else begin
        if (completed != CountMax) begin
          completed_next = completed + COUNT_WIDTH'(1);
        end
        if (remaining != '0) begin
          remaining_next = remaining - COUNT_WIDTH'(1);
        end
        if (remaining_next == '0) begin
          do_close     = 1'b1;
          close_status = ST_OK;
        end
      end
    end

    if (do_close) begin
      if (saved_flags_next[FLAG_STOP]) begin
        ent[num] = '{bus_action: ACT_STOP, byte_value: 8'd0, nack_seen: 1'b0};
        num      = num + 2'd1;
      end
      active_next = 1'b0;
      status      = close_status;
    end
  end

  assign bundle = '{entry: ent, count: num, bytes_done: done_view, status: status};

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      reading     <= 1'b0;
      remaining   <= '0;
      completed   <= '0;
      saved_flags <= '0;
    end else if (commit) begin
      active      <= active_next;
      reading     <= reading_next;
      remaining   <= remaining_next;
      completed   <= completed_next;
      saved_flags <= saved_flags_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cmts_drain.sv =====
`default_nettype none

module i2cmts_drain
  import i2cmts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  bundle_t   bundle,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  bundle_t    held;
  logic [1:0] pos;
  logic       busy;
  logic       last_pos;
  action_t    cur;

  assign last_pos  = (pos == held.count - 2'd1);
  assign cur       = held.entry[pos];
  assign out_valid = busy;
  // A new bundle may land in the cycle its predecessor's final beat leaves.
  assign can_load  = !busy || (out_ready && last_pos);

  assign out_data = '{bus_action: cur.bus_action, byte_value: cur.byte_value,
                      nack_seen: cur.nack_seen, bytes_done: held.bytes_done,
                      status: held.status, last: last_pos};

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= 2'd0;
    end else if (busy && out_ready) begin
      if (last_pos) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2c_master_transaction_sequencer.sv =====
`default_nettype none

// Byte-level I2C master transaction sequencer. Each input beat (begin or byte
// step) is held in an input register, evaluated combinationally against the
// transaction state, and its one to three bus actions are loaded together into
// a result buffer that hands them out one beat per cycle while out_ready is
// high. A beat passes the input register and then the result buffer before its
// first result appears. Single-result items stream at one per cycle while
// out_ready is high, as the next item loads when the last result leaves.
// Counters are COUNT_WIDTH bits wide and saturate.
module i2c_master_transaction_sequencer
  import i2cmts_pkg::*;
#(
  parameter int COUNT_WIDTH = I2CMTS_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  in_item_t in_q;
  logic     in_full;
  logic     can_load;
  logic     load;
  bundle_t  bundle;

  assign load     = in_full && can_load;
  assign in_ready = !in_full || load;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  i2cmts_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .item  (in_q),
    .commit(load),
    .bundle(bundle)
  );

  i2cmts_drain u_drain (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .bundle   (bundle),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // A result beat that is not the last of its item is followed by another.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("result burst broken before its last beat");

  // A start condition is never the final action of an item.
  a_start_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bus_action == ACT_START |-> !out_data.last)
    else $error("start condition marked as last result");

  // A step with no open transaction gives a single idle beat.
  a_idle_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_IDLE |->
      out_data.last && out_data.bus_action == ACT_NONE)
    else $error("idle status with unexpected action");

  // A held item that could not move on stays in the input register.
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_full && !load |=> in_full)
    else $error("input item lost");

endmodule

`default_nettype wire
